// ===== src/ans_pkg.sv =====
// ----------------------------------------------------------------------------
// ans_pkg: shared types and constants of the Annex B NAL splitter
// Window depth, result item layout and the start code byte values.
// ----------------------------------------------------------------------------
package ans_pkg;

  localparam int WIN_DEPTH = 5;
  localparam int MAX_RES   = 5;
  localparam int FILL_W    = 3;
  localparam int SKIP_W    = 2;
  localparam int CNT_W     = 3;
  localparam int CODE_W    = 3;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  localparam logic [CODE_W-1:0] CODE_NONE  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_SHORT = 3'd3;
  localparam logic [CODE_W-1:0] CODE_LONG  = 3'd4;

  typedef struct packed {
    logic [7:0] nal_byte;
    logic       first_of_nal;
    logic       last_of_nal;
    logic       empty_nal;
    logic       end_of_run;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] item;
    logic [CNT_W-1:0]      cnt;
  } batch_t;

endpackage

// ===== src/ans_core.sv =====
// ----------------------------------------------------------------------------
// ans_core: look-ahead window and start code decision
// Holds the five-byte window and parse state; turns one staged byte into
// a batch of up to five results.
// ----------------------------------------------------------------------------
module ans_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     stg_byte,
  input  logic           stg_last,
  output ans_pkg::batch_t res
);

  logic [ans_pkg::WIN_DEPTH-1:0][7:0] win_r, win_nxt;
  logic [ans_pkg::FILL_W-1:0]         fill_r, fill_nxt;
  logic [ans_pkg::SKIP_W-1:0]         skip_r, skip_nxt;
  logic                               inside_r, inside_nxt;
  logic                               has_r, has_nxt;

  logic [ans_pkg::WIN_DEPTH-1:0][7:0] w;
  logic [ans_pkg::FILL_W-1:0]         n;
  logic [7:0]                         wx [ans_pkg::WIN_DEPTH+4];
  logic [ans_pkg::CODE_W-1:0]         code [ans_pkg::WIN_DEPTH+1];

  // window with the new byte appended, padded with zeros past the end
  always_comb begin
    w = win_r;
    w[fill_r] = stg_byte;
    n = fill_r + 3'd1;
    for (int j = 0; j < ans_pkg::WIN_DEPTH + 4; j++) begin
      wx[j] = (j < ans_pkg::WIN_DEPTH) ? w[j] : 8'h00;
    end
  end

  // start code length at each position, only fully inside the valid bytes
  always_comb begin
    for (int k = 0; k <= ans_pkg::WIN_DEPTH; k++) begin
      if ((k + 3) <= int'(n) && wx[k] == ans_pkg::SC_ZERO && wx[k+1] == ans_pkg::SC_ZERO &&
          wx[k+2] == ans_pkg::SC_ONE) begin
        code[k] = ans_pkg::CODE_SHORT;
      end else if ((k + 4) <= int'(n) && wx[k] == ans_pkg::SC_ZERO &&
                   wx[k+1] == ans_pkg::SC_ZERO && wx[k+2] == ans_pkg::SC_ZERO &&
                   wx[k+3] == ans_pkg::SC_ONE) begin
        code[k] = ans_pkg::CODE_LONG;
      end else begin
        code[k] = ans_pkg::CODE_NONE;
      end
    end
  end

  // decide positions in order; flush decides all, a full window only the oldest
  always_comb begin
    logic en;
    logic nb;
    skip_nxt   = skip_r;
    inside_nxt = inside_r;
    has_nxt    = has_r;
    res        = '0;
    for (int k = 0; k < ans_pkg::WIN_DEPTH; k++) begin
      en = stg_last ? (k < int'(n)) : (int'(n) == ans_pkg::WIN_DEPTH && k == 0);
      nb = (stg_last && (k + 1) >= int'(n)) || code[k+1] != ans_pkg::CODE_NONE;
      if (en) begin
        if (skip_nxt != '0) begin
          skip_nxt = skip_nxt - 2'd1;
          if (skip_nxt == '0 && nb) begin
            res.item[res.cnt].empty_nal = 1'b1;
            res.cnt = res.cnt + 3'd1;
          end
        end else if (code[k] != ans_pkg::CODE_NONE) begin
          inside_nxt = 1'b1;
          has_nxt    = 1'b0;
          skip_nxt   = ans_pkg::SKIP_W'(code[k] - 3'd1);
        end else if (inside_nxt) begin
          res.item[res.cnt].nal_byte     = w[k];
          res.item[res.cnt].first_of_nal = !has_nxt;
          res.item[res.cnt].last_of_nal  = nb;
          res.cnt = res.cnt + 3'd1;
          has_nxt = 1'b1;
        end
      end
    end
    if (res.cnt != '0) begin
      res.item[res.cnt - 3'd1].end_of_run = 1'b1;
    end
  end

  always_comb begin
    if (int'(n) == ans_pkg::WIN_DEPTH) begin
      for (int j = 0; j < ans_pkg::WIN_DEPTH - 1; j++) begin
        win_nxt[j] = w[j+1];
      end
      win_nxt[ans_pkg::WIN_DEPTH-1] = 8'h00;
      fill_nxt = ans_pkg::FILL_W'(ans_pkg::WIN_DEPTH - 1);
    end else begin
      win_nxt  = w;
      fill_nxt = n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      fill_r   <= '0;
      skip_r   <= '0;
      inside_r <= 1'b0;
      has_r    <= 1'b0;
    end else if (step) begin
      if (stg_last) begin
        win_r    <= '0;
        fill_r   <= '0;
        skip_r   <= '0;
        inside_r <= 1'b0;
        has_r    <= 1'b0;
      end else begin
        win_r    <= win_nxt;
        fill_r   <= fill_nxt;
        skip_r   <= skip_nxt;
        inside_r <= inside_nxt;
        has_r    <= has_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_one_per_byte: assert property (@(posedge clk) disable iff (!rst_n)
    step && !stg_last |-> res.cnt <= 3'd1)
    else $error("more than one result from a mid-buffer byte");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && stg_last |=> fill_r == '0 && skip_r == '0 && !inside_r && !has_r)
    else $error("state not cleared after buffer end");
`endif

endmodule

// ===== src/ans_batch.sv =====
// ----------------------------------------------------------------------------
// ans_batch: result register
// Holds one batch of results and hands them out one per request.
// ----------------------------------------------------------------------------
module ans_batch (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ans_pkg::batch_t  batch,
  input  logic             out_ready,
  output logic             out_valid,
  output ans_pkg::result_t out_item,
  output logic             free
);

  ans_pkg::result_t [ans_pkg::MAX_RES-1:0] item_r;
  logic [ans_pkg::CNT_W-1:0]               left_r;
  logic                                    pop;

  assign out_valid = left_r != '0;
  assign out_item  = item_r[0];
  assign pop       = out_valid && out_ready;
  assign free      = left_r == '0 || (left_r == 3'd1 && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (load) begin
      left_r <= batch.cnt;
    end else if (pop) begin
      left_r <= left_r - 3'd1;
    end
  end

  // payload shifts toward the head; no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= batch.item;
    end else if (pop) begin
      for (int j = 0; j < ans_pkg::MAX_RES - 1; j++) begin
        item_r[j] <= item_r[j+1];
      end
      item_r[ans_pkg::MAX_RES-1] <= '0;
    end
  end

endmodule

// ===== src/annexb_nal_splitter.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_splitter: Annex B byte stream to NAL unit payload bytes
// Input register, window decision core and result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: one buffer byte per request, in_last_in_buffer on the
//                  final byte of a buffer.
//   out_* channel: NAL payload bytes with first/last marks, or an empty-NAL
//                  request for a zero-length unit; out_end_of_run marks the
//                  last result caused by one input byte.
//   Start codes and any bytes before the first one are never emitted.
//   A byte is held in the input register, then its results are loaded into
//   the result register; a payload byte leaves the window four bytes later
//   (or at the buffer end).
//   Throughput: one byte per cycle mid-buffer while results are taken, set by
//   the single-pass decision on the oldest window byte. A buffer-end byte
//   flushes the window as up to five results, drained one per cycle while
//   out_ready is high; the next buffer's first bytes carry no results and
//   pass at once; a short buffer's end byte right behind waits for the drain.
//   Reset (rst_n low, synchronous) empties the window and both registers' valid
//   state (payloads are not reset). When the receiver stalls, results hold in
//   the result register and the input register fills; in_ready drops only while both are occupied.
// ----------------------------------------------------------------------------
module annexb_nal_splitter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  input  logic       in_last_in_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_nal_byte,
  output logic       out_first_of_nal,
  output logic       out_last_of_nal,
  output logic       out_empty_nal,
  output logic       out_end_of_run
);

  // input register
  logic       stg_v_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;

  logic             step;
  logic             free;
  ans_pkg::batch_t  res;
  ans_pkg::result_t out_item;

  // a staged byte moves on when its results fit; a byte with no results
  // never waits for the result register
  assign step     = stg_v_r && (res.cnt == '0 || free);
  assign in_ready = !stg_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_v_r <= 1'b1;
    end else if (step) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_byte_in;
      stg_last_r <= in_last_in_buffer;
    end
  end

  ans_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .stg_byte (stg_byte_r),
    .stg_last (stg_last_r),
    .res      (res)
  );

  ans_batch u_batch (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res.cnt != '0),
    .batch     (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .free      (free)
  );

  assign out_nal_byte     = out_item.nal_byte;
  assign out_first_of_nal = out_item.first_of_nal;
  assign out_last_of_nal  = out_item.last_of_nal;
  assign out_empty_nal    = out_item.empty_nal;
  assign out_end_of_run   = out_item.end_of_run;

`ifndef ASSERT_OFF
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r && !step |=> stg_v_r && $stable(stg_byte_r) && $stable(stg_last_r))
    else $error("staged byte lost while blocked");
`endif

endmodule
